// ----- hdl/mrlp_pkg.sv -----
// shared constants, result type and command word lookup for the reply line parser
package mrlp_pkg;

   localparam int MAX_ARGS   = 4;
   localparam int WORD_LIMIT = 15;
   localparam int WL_W       = $clog2(WORD_LIMIT + 1);
   localparam int WB_W       = $clog2(WORD_LIMIT);
   localparam int IDX_W      = $clog2(MAX_ARGS + 1);
   localparam int AIX_W      = $clog2(MAX_ARGS);
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [15:0] KEY_LEN_RESET = 16'd1000;

   localparam logic [3:0] KIND_NONE     = 4'd0;
   localparam logic [3:0] KIND_EMPTY    = 4'd1;
   localparam logic [3:0] KIND_NUMBER   = 4'd2;
   localparam logic [3:0] KIND_VALUE    = 4'd3;
   localparam logic [3:0] KIND_NONCE    = 4'd4;
   localparam logic [3:0] KIND_VERSION  = 4'd5;
   localparam logic [3:0] KIND_CLI_ERR  = 4'd6;
   localparam logic [3:0] KIND_SRV_ERR  = 4'd7;
   localparam logic [3:0] KIND_ERROR    = 4'd8;
   localparam logic [3:0] KIND_STORED   = 4'd9;
   localparam logic [3:0] KIND_NO_STORE = 4'd10;
   localparam logic [3:0] KIND_DELETED  = 4'd11;
   localparam logic [3:0] KIND_MISSING  = 4'd12;
   localparam logic [3:0] KIND_END      = 4'd13;

   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_BAD      = 2'd1;
   localparam logic [1:0] STATUS_KEY_LONG = 2'd2;

   typedef logic [WORD_LIMIT-1:0][7:0] word_buf_type;

   typedef struct packed {
      logic [3:0]         reply_kind;
      logic               tilde_prefix;
      logic [1:0]         line_status;
      logic [15:0]        line_length;
      logic [15:0]        key_pos;
      logic [15:0]        key_length;
      logic [2:0]         arg_count;
      logic signed [63:0] arg_first;
      logic signed [63:0] arg_second;
      logic signed [63:0] arg_third;
      logic signed [63:0] arg_fourth;
   } rsp_payload_type;

   // text is left aligned, first character in the top byte
   function automatic logic word_eq(word_buf_type wb, logic [WL_W-1:0] len,
                                    logic [95:0] text, int tlen);
      logic ok;
      ok = (int'(len) == tlen);
      for (int i = 0; i < 12; i++) begin
         if (i < tlen && wb[i] != text[95-8*i -: 8]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic logic [3:0] word_kind(word_buf_type wb, logic [WL_W-1:0] len);
      logic [3:0] k;
      k = KIND_NONE;
      if (len == '0) begin
         k = KIND_EMPTY;
      end else if (word_eq(wb, len, {"VALUE", 56'h0}, 5)) begin
         k = KIND_VALUE;
      end else if (word_eq(wb, len, {"NONCE", 56'h0}, 5)) begin
         k = KIND_NONCE;
      end else if (word_eq(wb, len, {"VERSION", 40'h0}, 7)) begin
         k = KIND_VERSION;
      end else if (word_eq(wb, len, {"CLIENT", "_ERROR"}, 12)) begin
         k = KIND_CLI_ERR;
      end else if (word_eq(wb, len, {"SERVER", "_ERROR"}, 12)) begin
         k = KIND_SRV_ERR;
      end else if (word_eq(wb, len, {"ERROR", 56'h0}, 5)) begin
         k = KIND_ERROR;
      end else if (word_eq(wb, len, {"STORED", 48'h0}, 6)) begin
         k = KIND_STORED;
      end else if (word_eq(wb, len, {"NOT", "_STORED", 16'h0}, 10)) begin
         k = KIND_NO_STORE;
      end else if (word_eq(wb, len, {"DELETED", 40'h0}, 7)) begin
         k = KIND_DELETED;
      end else if (word_eq(wb, len, {"NOT", "_FOUND", 24'h0}, 9)) begin
         k = KIND_MISSING;
      end else if (word_eq(wb, len, {"END", 72'h0}, 3)) begin
         k = KIND_END;
      end
      return k;
   endfunction

endpackage

// ----- hdl/mrlp_if.sv -----
// valid/ready channel interfaces for reply bytes and parsed line results
interface mrlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface mrlp_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         reply_kind;
   logic               tilde_prefix;
   logic [1:0]         line_status;
   logic [15:0]        line_length;
   logic [15:0]        key_pos;
   logic [15:0]        key_length;
   logic [2:0]         arg_count;
   logic signed [63:0] arg_first;
   logic signed [63:0] arg_second;
   logic signed [63:0] arg_third;
   logic signed [63:0] arg_fourth;
   modport source (output valid, output reply_kind, output tilde_prefix,
                   output line_status, output line_length, output key_pos,
                   output key_length, output arg_count, output arg_first,
                   output arg_second, output arg_third, output arg_fourth,
                   input ready);
   modport sink (input valid, input reply_kind, input tilde_prefix,
                 input line_status, input line_length, input key_pos,
                 input key_length, input arg_count, input arg_first,
                 input arg_second, input arg_third, input arg_fourth,
                 output ready);
endinterface

// ----- hdl/mrlp_parser.sv -----
// per byte line state machine: phase walk, word buffer, argument accumulation
module mrlp_parser import mrlp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [7:0]      in_byte,
   input  logic [15:0]     key_limit,
   output logic            out_valid,
   output rsp_payload_type out_data
);

   localparam logic [3:0] PH_CMD  = 4'd0;
   localparam logic [3:0] PH_SPC  = 4'd1;
   localparam logic [3:0] PH_KEY  = 4'd2;
   localparam logic [3:0] PH_INTS = 4'd3;
   localparam logic [3:0] PH_INT  = 4'd4;
   localparam logic [3:0] PH_SKIP = 4'd5;
   localparam logic [3:0] PH_TEXT = 4'd6;
   localparam logic [3:0] PH_EOLN = 4'd7;
   localparam logic [3:0] PH_LF   = 4'd8;

   localparam logic [1:0] ARG_KEEP  = 2'd0;
   localparam logic [1:0] ARG_ZERO  = 2'd1;
   localparam logic [1:0] ARG_DIGIT = 2'd2;
   localparam logic [1:0] ARG_NEG   = 2'd3;

   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   localparam logic [63:0] LIM_DIV10 = 64'h0CCC_CCCC_CCCC_CCCC;
   localparam int STEPS = 5;

   typedef struct packed {
      logic [3:0]       phase;
      logic [WL_W-1:0]  wlen;
      logic [3:0]       kind;
      logic             tilde;
      logic             neg;
      logic             nodig;
      logic             bad;
      logic [15:0]      koff;
      logic [15:0]      klen;
      logic [15:0]      llen;
      logic [IDX_W-1:0] idx;
   } line_state_type;

   function automatic logic [15:0] sat16(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   line_state_type              line_ff, line_in, snap;
   logic [MAX_ARGS-1:0][63:0]   arg_ff, arg_in, arg_base, arg_new, arg_out;
   word_buf_type                word_buf_ff;

   logic                        is_blank, is_eol, is_letter, is_digit;
   logic [3:0]                  dval, km_pre;
   logic [63:0]                 cur_arg, mul10, neg_val, arg_val;
   logic                        ovf;
   logic [1:0]                  arg_op;
   logic [IDX_W-1:0]            arg_sel;
   logic                        fresh, pre_emit, eol_emit;
   logic                        wb_we;
   logic [WB_W-1:0]             wb_idx;
   logic [1:0]                  status;

   assign is_blank  = (in_byte == CH_SP) || (in_byte == CH_TAB);
   assign is_eol    = (in_byte == CH_CR) || (in_byte == CH_LF);
   assign is_letter = (in_byte >= "a" && in_byte <= "z") || (in_byte >= "A" && in_byte <= "Z")
                      || (in_byte == CH_UNDER);
   assign is_digit  = (in_byte >= "0") && (in_byte <= "9");
   assign dval      = in_byte[3:0];
   assign km_pre    = word_kind(word_buf_ff, line_ff.wlen);

   assign cur_arg = (line_ff.idx < IDX_W'(MAX_ARGS)) ? arg_ff[line_ff.idx[AIX_W-1:0]] : '0;
   assign mul10   = {cur_arg[60:0], 3'b000} + {cur_arg[62:0], 1'b0} + 64'(dval);
   assign neg_val = 64'd0 - cur_arg;
   assign ovf     = (cur_arg > LIM_DIV10) ||
                    ((cur_arg == LIM_DIV10) && (dval > (line_ff.neg ? 4'd8 : 4'd7)));

   always_comb begin
      line_state_type ln;
      logic           done;
      ln       = line_ff;
      snap     = line_ff;
      done     = !in_valid;
      arg_op   = ARG_KEEP;
      arg_sel  = line_ff.idx;
      fresh    = 1'b0;
      pre_emit = 1'b0;
      eol_emit = 1'b0;
      wb_we    = 1'b0;
      wb_idx   = line_ff.wlen[WB_W-1:0];

      // pending lone cr: this byte closes the previous line first
      if (in_valid && line_ff.phase == PH_LF) begin
         pre_emit = 1'b1;
         if (in_byte == CH_LF) begin
            snap.llen = sat16(line_ff.llen);
            done      = 1'b1;
         end
         ln = '0;
      end

      for (int s = 0; s < STEPS; s++) begin
         if (!done) begin
            unique case (ln.phase)
               PH_CMD: begin
                  if (ln.wlen == '0 && !ln.tilde && in_byte == CH_TILDE) begin
                     ln.tilde = 1'b1;
                     ln.llen  = sat16(ln.llen);
                     done     = 1'b1;
                  end else if (is_letter && ln.wlen < WL_W'(WORD_LIMIT)) begin
                     wb_we   = 1'b1;
                     wb_idx  = ln.wlen[WB_W-1:0];
                     ln.wlen = ln.wlen + WL_W'(1);
                     ln.llen = sat16(ln.llen);
                     done    = 1'b1;
                  end else if (ln.wlen == '0 && (is_digit || in_byte == CH_MINUS)) begin
                     ln.kind  = KIND_NUMBER;
                     ln.idx   = '0;
                     ln.phase = PH_INTS;
                  end else if (ln.wlen >= WL_W'(WORD_LIMIT) || !(is_blank || is_eol)) begin
                     ln.phase = PH_SKIP;
                  end else begin
                     ln.kind = (ln.wlen == '0) ? KIND_EMPTY : km_pre;
                     if (ln.kind == KIND_NONE) begin
                        ln.phase = PH_SKIP;
                     end else begin
                        ln.koff  = 16'(ln.wlen) + 16'(ln.tilde);
                        ln.phase = PH_SPC;
                     end
                  end
               end
               PH_SPC: begin
                  if (is_blank) begin
                     ln.koff = sat16(ln.koff);
                     ln.llen = sat16(ln.llen);
                     done    = 1'b1;
                  end else if (is_eol) begin
                     ln.phase = PH_EOLN;
                  end else if (ln.kind >= KIND_STORED) begin
                     ln.phase = PH_SKIP;
                  end else if (ln.kind >= KIND_VERSION) begin
                     ln.phase = PH_TEXT;
                  end else begin
                     ln.phase = PH_KEY;
                  end
               end
               PH_KEY: begin
                  if (in_byte > CH_SP) begin
                     ln.klen = sat16(ln.klen);
                     ln.llen = sat16(ln.llen);
                     done    = 1'b1;
                  end else begin
                     ln.idx = '0;
                     if (!(is_blank || is_eol)) begin
                        ln.phase = PH_SKIP;
                     end else if (ln.kind == KIND_NONCE) begin
                        ln.phase = is_eol ? PH_EOLN : PH_SKIP;
                     end else begin
                        ln.phase = PH_INTS;
                     end
                  end
               end
               PH_INTS: begin
                  if (is_blank) begin
                     ln.llen = sat16(ln.llen);
                     done    = 1'b1;
                  end else if (is_eol) begin
                     ln.phase = PH_EOLN;
                  end else if (ln.idx >= IDX_W'(MAX_ARGS)) begin
                     ln.phase = PH_SKIP;
                  end else begin
                     arg_op   = ARG_ZERO;
                     arg_sel  = ln.idx;
                     fresh    = 1'b1;
                     ln.neg   = 1'b0;
                     ln.nodig = 1'b1;
                     ln.phase = PH_INT;
                     if (in_byte == CH_MINUS) begin
                        ln.neg  = 1'b1;
                        ln.llen = sat16(ln.llen);
                        done    = 1'b1;
                     end
                  end
               end
               PH_INT: begin
                  if (ln.idx >= IDX_W'(MAX_ARGS)) begin
                     ln.phase = PH_SKIP;
                  end else if (is_digit) begin
                     arg_sel = ln.idx;
                     if (!fresh && ovf) begin
                        arg_op   = ARG_ZERO;
                        ln.phase = PH_SKIP;
                     end else begin
                        arg_op   = ARG_DIGIT;
                        ln.nodig = 1'b0;
                        ln.llen  = sat16(ln.llen);
                        done     = 1'b1;
                     end
                  end else begin
                     if (!fresh && ln.neg) begin
                        arg_op  = ARG_NEG;
                        arg_sel = ln.idx;
                     end
                     ln.idx = ln.idx + IDX_W'(1);
                     if (ln.nodig || !(is_blank || is_eol)) begin
                        ln.phase = PH_SKIP;
                     end else begin
                        ln.phase = PH_INTS;
                     end
                  end
               end
               PH_SKIP: begin
                  ln.bad   = 1'b1;
                  ln.phase = PH_TEXT;
               end
               PH_TEXT: begin
                  if (is_eol) begin
                     ln.phase = PH_EOLN;
                  end else begin
                     if (in_byte < CH_SP && in_byte != CH_TAB) begin
                        ln.bad = 1'b1;
                     end
                     ln.llen = sat16(ln.llen);
                     done    = 1'b1;
                  end
               end
               PH_EOLN: begin
                  ln.llen = sat16(ln.llen);
                  done    = 1'b1;
                  if (in_byte == CH_CR) begin
                     ln.phase = PH_LF;
                  end else begin
                     eol_emit = 1'b1;
                     snap     = ln;
                     ln       = '0;
                  end
               end
               default: begin
                  ln = '0;
               end
            endcase
         end
      end
      line_in = ln;
   end

   always_comb begin
      arg_base = pre_emit ? '0 : arg_ff;
      unique case (arg_op)
         ARG_ZERO:  arg_val = '0;
         ARG_DIGIT: arg_val = fresh ? 64'(dval) : mul10;
         ARG_NEG:   arg_val = neg_val;
         default:   arg_val = '0;
      endcase
      arg_new = arg_base;
      if (arg_op != ARG_KEEP && arg_sel < IDX_W'(MAX_ARGS)) begin
         arg_new[arg_sel[AIX_W-1:0]] = arg_val;
      end
      arg_in  = eol_emit ? '0 : arg_new;
      arg_out = pre_emit ? arg_ff : arg_new;
      for (int j = 0; j < MAX_ARGS; j++) begin
         if (IDX_W'(j) >= snap.idx) begin
            arg_out[j] = '0;
         end
      end
   end

   always_comb begin
      if (snap.bad) begin
         status = STATUS_BAD;
      end else if (snap.klen > key_limit) begin
         status = STATUS_KEY_LONG;
      end else begin
         status = STATUS_GOOD;
      end
      out_valid             = pre_emit || eol_emit;
      out_data.reply_kind   = snap.kind;
      out_data.tilde_prefix = snap.tilde;
      out_data.line_status  = status;
      out_data.line_length  = snap.llen;
      out_data.key_pos      = snap.koff;
      out_data.key_length   = snap.klen;
      out_data.arg_count    = 3'(snap.idx);
      out_data.arg_first    = arg_out[0];
      out_data.arg_second   = arg_out[1];
      out_data.arg_third    = arg_out[2];
      out_data.arg_fourth   = arg_out[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
         arg_ff  <= '0;
      end else if (in_valid) begin
         line_ff <= line_in;
         arg_ff  <= arg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && wb_we) begin
         word_buf_ff[wb_idx] <= in_byte;
      end
   end

endmodule

// ----- hdl/memcache_response_line_parser.sv -----
// top level: byte input register, key length register, parser, result queue
//
//  channel  | dir | payload                                    | accepted when
//  req_if   | in  | data_byte                                  | valid && ready
//  rsp_if   | out | kind, tilde, status, lengths, count, args  | valid && ready
//  csr_*    | in  | max_key_length                             | csr_wr_en
//
// one byte per cycle while req_if.ready is high; a result passes the byte register and queue
// the byte register feeds the parser, whose result goes into a four deep queue
// req_if.ready drops only when the queue plus the byte in flight fill it
// reset clears the line state, the queue and sets the key limit to 1000
module memcache_response_line_parser import mrlp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mrlp_req_if.sink    req_if,
   mrlp_rsp_if.source  rsp_if,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0]          max_key_ff;
   logic                 s1_valid_ff;
   logic [7:0]           s1_byte_ff;
   logic                 res_valid;
   rsp_payload_type      res_data;
   rsp_payload_type      fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 push, pop;
   rsp_payload_type      head;

   assign req_if.ready = (count_ff + (FIFO_AW+1)'(s1_valid_ff)) < (FIFO_AW+1)'(FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_key_ff <= KEY_LEN_RESET;
      end else if (csr_wr_en) begin
         max_key_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_if.valid && req_if.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_byte_ff <= req_if.data_byte;
      end
   end

   mrlp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid_ff),
      .in_byte     (s1_byte_ff),
      .key_limit   (max_key_ff),
      .out_valid   (res_valid),
      .out_data    (res_data)
   );

   assign push = res_valid;
   assign pop  = rsp_if.valid && rsp_if.ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (FIFO_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= res_data;
      end
   end

   assign head = fifo_ff[rd_ptr_ff];

   assign rsp_if.valid        = (count_ff != '0);
   assign rsp_if.reply_kind   = head.reply_kind;
   assign rsp_if.tilde_prefix = head.tilde_prefix;
   assign rsp_if.line_status  = head.line_status;
   assign rsp_if.line_length  = head.line_length;
   assign rsp_if.key_pos      = head.key_pos;
   assign rsp_if.key_length   = head.key_length;
   assign rsp_if.arg_count    = head.arg_count;
   assign rsp_if.arg_first    = head.arg_first;
   assign rsp_if.arg_second   = head.arg_second;
   assign rsp_if.arg_third    = head.arg_third;
   assign rsp_if.arg_fourth   = head.arg_fourth;

endmodule

// ----- hdl/mrlp_checker.sv -----
// port level checks on the result channel, bound to the top level
module mrlp_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [3:0]         reply_kind,
   input logic [1:0]         line_status,
   input logic [2:0]         arg_count,
   input logic signed [63:0] arg_first
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (line_status != 2'd3) && (arg_count <= 3'd4) && (reply_kind <= 4'd13))
      else $error("result field out of range");

   a_no_args_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (arg_count == 3'd0) |-> (arg_first == 64'sd0))
      else $error("unfinished argument not zero");

endmodule

bind memcache_response_line_parser mrlp_checker u_mrlp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .reply_kind  (rsp_if.reply_kind),
   .line_status (rsp_if.line_status),
   .arg_count   (rsp_if.arg_count),
   .arg_first   (rsp_if.arg_first)
);

// ----- bench/memcache_response_line_parser_tb.sv -----
// testbench for the reply line parser: byte stimulus, line prediction and result checking
module memcache_response_line_parser_tb;
   import mrlp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_TILDE = 8'h7e;
   localparam logic [7:0] CH_MINUS = 8'h2d;

   typedef enum logic [3:0] {
      P_CMD, P_SPC, P_KEY, P_INTS, P_INT, P_SKIP, P_TEXT, P_EOLN, P_LF
   } phase_type;

   class line_scoreboard;
      rsp_payload_type lines_q[$];
      int              errors;
      logic [15:0]     key_limit;
      phase_type       ph;
      logic [7:0]      wbuf[WORD_LIMIT];
      int              wlen;
      logic [3:0]      kind;
      bit              tilde, neg, nodig, bad;
      logic [15:0]     koff, klen, llen;
      int              aidx;
      logic [63:0]     args[MAX_ARGS];
      string           words[11];
      logic [3:0]      kinds[11];

      function new();
         string und;
         und = "_";
         words = '{"VALUE", "NONCE", "VERSION", {"CLIENT", und, "ERROR"},
                   {"SERVER", und, "ERROR"}, "ERROR", "STORED", {"NOT", und, "STORED"},
                   "DELETED", {"NOT", und, "FOUND"}, "END"};
         kinds = '{KIND_VALUE, KIND_NONCE, KIND_VERSION, KIND_CLI_ERR, KIND_SRV_ERR,
                   KIND_ERROR, KIND_STORED, KIND_NO_STORE, KIND_DELETED, KIND_MISSING,
                   KIND_END};
         key_limit = KEY_LEN_RESET;
         errors = 0;
         clear_line();
      endfunction

      function void clear_line();
         ph = P_CMD;
         wlen = 0;
         kind = KIND_NONE;
         {tilde, neg, nodig, bad} = '0;
         koff = '0;
         klen = '0;
         llen = '0;
         aidx = 0;
         foreach (args[i]) args[i] = '0;
      endfunction

      function logic [15:0] inc16(logic [15:0] v);
         return (v == 16'hffff) ? v : v + 16'd1;
      endfunction

      function bit is_blank(logic [7:0] b);
         return b == CH_SP || b == CH_TAB;
      endfunction

      function bit is_eol(logic [7:0] b);
         return b == CH_CR || b == CH_LF;
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= "0" && b <= "9";
      endfunction

      function logic [3:0] lookup();
         string s;
         logic [3:0] k;
         if (wlen == 0) return KIND_EMPTY;
         s = "";
         for (int i = 0; i < wlen; i++) s = {s, string'(wbuf[i])};
         k = KIND_NONE;
         foreach (words[i]) if (s == words[i]) k = kinds[i];
         return k;
      endfunction

      function void finish_line();
         rsp_payload_type r;
         r.reply_kind   = kind;
         r.tilde_prefix = tilde;
         r.line_status  = bad ? STATUS_BAD : (klen > key_limit ? STATUS_KEY_LONG : STATUS_GOOD);
         r.line_length  = llen;
         r.key_pos      = koff;
         r.key_length   = klen;
         r.arg_count    = 3'(aidx);
         r.arg_first    = (aidx > 0) ? args[0] : '0;
         r.arg_second   = (aidx > 1) ? args[1] : '0;
         r.arg_third    = (aidx > 2) ? args[2] : '0;
         r.arg_fourth   = (aidx > 3) ? args[3] : '0;
         lines_q.push_back(r);
         clear_line();
      endfunction

      function void note_byte(logic [7:0] b);
         bit          done, take;
         logic [63:0] lim, tt;
         int          d, last;
         lim = 64'h7fff_ffff_ffff_ffff;
         done = 0;
         take = 0;
         if (ph == P_LF) begin
            if (b == CH_LF) begin
               llen = inc16(llen);
               finish_line();
               return;
            end
            finish_line();
         end
         while (!done) begin
            case (ph)
               P_CMD: begin
                  if (wlen == 0 && !tilde && b == CH_TILDE) begin
                     tilde = 1;
                     take = 1;
                  end else if (((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_")
                               && wlen < WORD_LIMIT) begin
                     wbuf[wlen] = b;
                     wlen++;
                     take = 1;
                  end else if (wlen == 0 && (is_digit(b) || b == CH_MINUS)) begin
                     kind = KIND_NUMBER;
                     aidx = 0;
                     ph = P_INTS;
                  end else if (wlen >= WORD_LIMIT || !(is_blank(b) || is_eol(b))) begin
                     ph = P_SKIP;
                  end else begin
                     kind = lookup();
                     if (kind == KIND_NONE) begin
                        ph = P_SKIP;
                     end else begin
                        koff = 16'(wlen) + 16'(tilde);
                        ph = P_SPC;
                     end
                  end
               end
               P_SPC: begin
                  if (is_blank(b)) begin
                     koff = inc16(koff);
                     take = 1;
                  end else if (is_eol(b)) ph = P_EOLN;
                  else if (kind >= KIND_STORED) ph = P_SKIP;
                  else if (kind >= KIND_VERSION) ph = P_TEXT;
                  else ph = P_KEY;
               end
               P_KEY: begin
                  if (b > CH_SP) begin
                     klen = inc16(klen);
                     take = 1;
                  end else begin
                     aidx = 0;
                     if (!(is_blank(b) || is_eol(b))) ph = P_SKIP;
                     else if (kind == KIND_NONCE) ph = is_eol(b) ? P_EOLN : P_SKIP;
                     else ph = P_INTS;
                  end
               end
               P_INTS: begin
                  if (is_blank(b)) take = 1;
                  else if (is_eol(b)) ph = P_EOLN;
                  else if (aidx >= MAX_ARGS) ph = P_SKIP;
                  else begin
                     args[aidx] = '0;
                     neg = 0;
                     nodig = 1;
                     ph = P_INT;
                     if (b == CH_MINUS) begin
                        neg = 1;
                        take = 1;
                     end
                  end
               end
               P_INT: begin
                  if (aidx >= MAX_ARGS) ph = P_SKIP;
                  else if (is_digit(b)) begin
                     tt = args[aidx];
                     d = b - "0";
                     last = neg ? 8 : 7;
                     if (tt > lim / 10 || (tt == lim / 10 && d > last)) begin
                        args[aidx] = '0;
                        ph = P_SKIP;
                     end else begin
                        args[aidx] = tt * 10 + 64'(d);
                        nodig = 0;
                        take = 1;
                     end
                  end else begin
                     if (neg) args[aidx] = -args[aidx];
                     aidx++;
                     if (nodig || !(is_blank(b) || is_eol(b))) ph = P_SKIP;
                     else ph = P_INTS;
                  end
               end
               P_SKIP: begin
                  bad = 1;
                  ph = P_TEXT;
               end
               P_TEXT: begin
                  if (is_eol(b)) ph = P_EOLN;
                  else begin
                     if (b < CH_SP && b != CH_TAB) bad = 1;
                     take = 1;
                  end
               end
               P_EOLN: begin
                  llen = inc16(llen);
                  if (b == CH_CR) ph = P_LF;
                  else finish_line();
                  done = 1;
               end
               default: clear_line();
            endcase
            if (take) done = 1;
         end
         if (take) llen = inc16(llen);
      endfunction

      function void check_line(rsp_payload_type got);
         rsp_payload_type exp;
         if (lines_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat %p", got);
            return;
         end
         exp = lines_q.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10) $display("mismatch\n  expected %p\n  actual   %p", exp, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset;
   logic csr_wr_en;
   logic [15:0] csr_wr_data;
   mrlp_req_if req_if();
   mrlp_rsp_if rsp_if();

   memcache_response_line_parser u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   line_scoreboard sb = new();
   logic [7:0] bytes_q[$];
   int bytes_sent = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_count = 0;

   // result checking and receiver stall pattern, chosen at random among four modes
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_line({rsp_if.reply_kind, rsp_if.tilde_prefix, rsp_if.line_status,
                        rsp_if.line_length, rsp_if.key_pos, rsp_if.key_length,
                        rsp_if.arg_count, rsp_if.arg_first, rsp_if.arg_second,
                        rsp_if.arg_third, rsp_if.arg_fourth});
      end
      stall_count <= stall_count + 1;
      if (stall_count % 128 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= ($urandom_range(0, 1) == 0);
         2: rsp_if.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_if.ready <= (stall_count % 16 < 11);
      endcase
   end

   function automatic void add_str(string s);
      foreach (s[i]) bytes_q.push_back(s[i]);
   endfunction

   function automatic void add_blanks();
      repeat ($urandom_range(1, 3)) bytes_q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
   endfunction

   function automatic void add_key(int len);
      repeat (len) bytes_q.push_back($urandom_range(33, 126));
   endfunction

   function automatic void add_number();
      longint v;
      case ($urandom_range(0, 9))
         0: v = 64'h7fff_ffff_ffff_ffff;
         1: v = 64'h8000_0000_0000_0000;
         2: v = {$urandom, $urandom};
         3: v = -longint'($urandom_range(0, 1000));
         4: begin add_str("99999999999999999999"); return; end
         5: if ($urandom_range(0, 3) == 0) begin add_str("-"); return; end
            else v = $urandom;
         default: v = $urandom_range(0, 1000);
      endcase
      add_str($sformatf("%0d", v));
   endfunction

   function automatic void add_eol();
      case ($urandom_range(0, 2))
         0: add_str("\r\n");
         1: bytes_q.push_back(CH_LF);
         default: bytes_q.push_back(CH_CR);
      endcase
   endfunction

   function automatic void gen_line();
      int w, start;
      start = bytes_q.size();
      if ($urandom_range(0, 4) == 0) bytes_q.push_back(CH_TILDE);
      if ($urandom_range(0, 99) < 85) begin
         w = $urandom_range(0, 11);
         if (w == 11) begin
            repeat ($urandom_range(1, 5)) begin add_number(); add_blanks(); end
         end else begin
            add_str(sb.words[w]);
            if (w <= 1) begin
               add_blanks();
               add_key($urandom_range(1, 10));
               if (w == 0) repeat ($urandom_range(0, 5)) begin add_blanks(); add_number(); end
            end else if (w <= 5) begin
               if ($urandom_range(0, 3) != 0) begin add_blanks(); add_key($urandom_range(0, 12)); end
            end else if ($urandom_range(0, 7) == 0) begin
               add_blanks();
               add_key(2);
            end
         end
         if ($urandom_range(0, 9) == 0 && bytes_q.size() > start)
            bytes_q[$urandom_range(start, bytes_q.size() - 1)] = $urandom_range(0, 255);
      end else begin
         repeat ($urandom_range(1, 10)) bytes_q.push_back($urandom_range(0, 255));
      end
      add_eol();
   endfunction

   task automatic send_byte(logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      sb.note_byte(b);
      bytes_sent++;
      burst_left--;
   endtask

   task automatic send_all();
      while (bytes_q.size() > 0) send_byte(bytes_q.pop_front());
   endtask

   // flush any line held by a lone carriage return, drain, then write the key limit
   task automatic set_key_limit(logic [15:0] v);
      add_str("\n");
      send_all();
      req_if.valid <= 1'b0;
      while (sb.lines_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.key_limit = v;
   endtask

   initial begin
      #10ms;
      $display("memcache_response_line_parser_tb failed");
      $finish;
   end

   initial begin
      int spins;
      logic [15:0] limits[4];
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_if.valid <= 1'b0;
      req_if.data_byte <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_str("VALUE key 0 123 -9223372036854775808 9223372036854775807\r\n");
      add_str("~END\r\n~~END\n12345 -7\n-\n\r\r\n\n");
      add_str("NONCE abc\nNONCE abc d\nVERSION 1.2\001x\rEND\n");
      add_str("ABCDEFGHIJKLMNOP\nXYZ\nSTORED extra\nNOT_STORED\tDELETED\n");
      add_str("VALUE k 1 2 3 4 5\nVALUE k 9223372036854775808\n");
      add_str("VALUE k -9223372036854775809\nVALUE k 1x\nNOT_FOUND\r\n");
      add_str("CLIENT_ERROR bad\nSERVER_ERROR x\nERROR\n~ 5\n");
      send_all();

      limits = '{16'd0, 16'd4, KEY_LEN_RESET, 16'($urandom_range(1, 65534))};
      foreach (limits[k]) begin
         set_key_limit(limits[k]);
         while (bytes_sent < 420 + 300 * (k + 1)) begin
            gen_line();
            send_all();
         end
      end
      add_str("\n");
      send_all();
      req_if.valid <= 1'b0;

      spins = 0;
      while (sb.lines_q.size() > 0 && spins < 20000) begin
         @(posedge clock);
         spins++;
      end
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.lines_q.size() == 0) begin
         $display("memcache_response_line_parser_tb passed");
      end else begin
         $display("memcache_response_line_parser_tb failed");
      end
      $finish;
   end
endmodule
